>>> hdl/pts_pkg.sv
// Shared types and constants for the padded texture store.
// Used by padded_texture_store_top; no dependencies.
`default_nettype none

package pts_pkg;

    // Fixed field widths.
    localparam int CW     = 7;      // content / raw coordinate and size width
    localparam int SCW    = CW + 1; // stored coordinate width, holds size plus border
    localparam int COLOR_W = 32;

    // Request actions.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_RAW   = 2'd2;

    // Border modes.
    localparam logic [1:0] PAD_NONE  = 2'd0;
    localparam logic [1:0] PAD_WRAP  = 2'd1;
    localparam logic [1:0] PAD_CLAMP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0]         action;
        logic [CW-1:0]      coord_x;
        logic [CW-1:0]      coord_y;
        logic [COLOR_W-1:0] pixel_in;
    } t_req;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_out;
        logic               out_of_range;
        logic               has_transparency;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WR   = 4'b0010,
        S_RD   = 4'b0100,
        S_RDAT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

>>> hdl/pts_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/padded_texture_store_top.sv
// Top level of the padded texture store: request decode, border write
// sequencer and result register. Depends on pts_pkg and pts_ram.
//
//  Channel   Handshake              Payload     Notes
//  request   start & !busy          i_req       t_req, taken in idle only
//  result    o_res_valid (1 cycle)  o_res       t_res, cannot be held off
//  config    i_cfg_we               i_cfg_idx, i_cfg_data   no read-back
//
// Out-of-range and unused requests answer in the cycle after the request.
// Reads stay busy in S_RD (address) and S_RDAT (RAM data), then answer.
// A write holds busy while it stores each cell it touches: one inside
// the content, two on an edge, four on a corner, up to nine for one-pixel
// content; the single RAM port sets this. Reset is synchronous and clears
// control state and the transparency flag; the pixel store is not cleared.
`default_nettype none

module padded_texture_store_top
    import pts_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire t_req          i_req,
    output logic               o_res_valid,
    output t_res               o_res,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [CW-1:0] i_cfg_data
);

    localparam int PITCH = MAX_WIDTH + 2;
    localparam int ROWS  = MAX_HEIGHT + 2;
    localparam int DEPTH = PITCH * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    t_res   r_res, n_res;
    logic   r_transp, n_transp;
    logic [CW-1:0] r_cfg_w, n_cfg_w;
    logic [CW-1:0] r_cfg_h, n_cfg_h;
    logic [1:0]    r_cfg_mode, n_cfg_mode;

    logic [SCW-1:0]     r_cols [3];
    logic [SCW-1:0]     n_cols [3];
    logic [SCW-1:0]     r_rows [3];
    logic [SCW-1:0]     n_rows [3];
    logic [1:0]         r_nc, n_nc, r_nr, n_nr;
    logic [1:0]         r_ci, n_ci, r_ri, n_ri;
    logic [COLOR_W-1:0] r_color, n_color;

    // Decode of the request against the current configuration.
    logic [CW-1:0]  w, h;
    logic           pad_on, wrap;
    logic [SCW-1:0] sw, sh, xs, ys, px, py;
    logic           l_edge, r_edge, t_edge, b_edge;
    logic [SCW-1:0] l_col, r_col, t_row, b_row;
    logic           in_content, in_raw;

    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [COLOR_W-1:0] mem_rdata;

    always_comb begin
        if (r_cfg_w == '0) begin
            w = CW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h = CW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h = CW'(MAX_HEIGHT);
        end else begin
            h = r_cfg_h;
        end
        pad_on = (r_cfg_mode == PAD_WRAP) || (r_cfg_mode == PAD_CLAMP);
        wrap   = (r_cfg_mode == PAD_WRAP);

        sw = {1'b0, w} + (pad_on ? SCW'(2) : SCW'(0));
        sh = {1'b0, h} + (pad_on ? SCW'(2) : SCW'(0));
        xs = {1'b0, i_req.coord_x};
        ys = {1'b0, i_req.coord_y};
        px = xs + SCW'(pad_on);
        py = ys + SCW'(pad_on);

        l_edge = pad_on && (px == SCW'(1));
        r_edge = pad_on && (px == sw - SCW'(2));
        t_edge = pad_on && (py == SCW'(1));
        b_edge = pad_on && (py == sh - SCW'(2));

        // Wrap copies an edge to the opposite border, clamp to the adjacent one.
        l_col = wrap ? (sw - SCW'(1)) : '0;
        r_col = wrap ? '0 : (sw - SCW'(1));
        t_row = wrap ? (sh - SCW'(1)) : '0;
        b_row = wrap ? '0 : (sh - SCW'(1));

        in_content = (i_req.coord_x < w) && (i_req.coord_y < h);
        in_raw     = (xs < sw) && (ys < sh);
    end

    assign mem_addr = AW'(r_rows[r_ri]) * AW'(PITCH) + AW'(r_cols[r_ci]);

    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        n_res       = r_res;
        n_transp    = r_transp;
        n_cfg_w     = r_cfg_w;
        n_cfg_h     = r_cfg_h;
        n_cfg_mode  = r_cfg_mode;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_nc        = r_nc;
        n_nr        = r_nr;
        n_ci        = r_ci;
        n_ri        = r_ri;
        n_color     = r_color;
        mem_we      = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  n_cfg_w    = i_cfg_data;
                REG_HEIGHT: n_cfg_h    = i_cfg_data;
                REG_MODE:   n_cfg_mode = i_cfg_data[1:0];
                default:    ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ci    = '0;
                    n_ri    = '0;
                    n_nc    = 2'd1;
                    n_nr    = 2'd1;
                    n_color = i_req.pixel_in;
                    n_res   = '{pixel_out: '0, out_of_range: 1'b0,
                                has_transparency: r_transp};
                    case (i_req.action)
                        ACT_WRITE: begin
                            if (!in_content) begin
                                n_res.out_of_range = 1'b1;
                                n_res_valid        = 1'b1;
                            end else begin
                                if (i_req.pixel_in[31:24] != ALPHA_OPAQUE) begin
                                    n_transp = 1'b1;
                                end
                                // Column and row lists; the product of the two
                                // covers the pixel, its edge copies and corners.
                                n_cols[0] = px;
                                n_cols[1] = l_edge ? l_col : r_col;
                                n_cols[2] = r_col;
                                n_rows[0] = py;
                                n_rows[1] = t_edge ? t_row : b_row;
                                n_rows[2] = b_row;
                                n_nc = 2'd1 + {1'b0, l_edge} + {1'b0, r_edge};
                                n_nr = 2'd1 + {1'b0, t_edge} + {1'b0, b_edge};
                                n_state = S_WR;
                            end
                        end
                        ACT_READ: begin
                            if (!in_content) begin
                                n_res.out_of_range = 1'b1;
                                n_res_valid        = 1'b1;
                            end else begin
                                n_cols[0] = px;
                                n_rows[0] = py;
                                n_state   = S_RD;
                            end
                        end
                        ACT_RAW: begin
                            if (!in_raw) begin
                                n_res.out_of_range = 1'b1;
                                n_res_valid        = 1'b1;
                            end else begin
                                n_cols[0] = xs;
                                n_rows[0] = ys;
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WR: begin
                mem_we = 1'b1;
                if (r_ci == r_nc - 2'd1) begin
                    n_ci = '0;
                    if (r_ri == r_nr - 2'd1) begin
                        n_res       = '{pixel_out: '0, out_of_range: 1'b0,
                                        has_transparency: r_transp};
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_ri = r_ri + 2'd1;
                    end
                end else begin
                    n_ci = r_ci + 2'd1;
                end
            end
            S_RD: begin
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_res       = '{pixel_out: mem_rdata, out_of_range: 1'b0,
                                has_transparency: r_transp};
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_transp    <= 1'b0;
            r_cfg_w     <= CW'(64);
            r_cfg_h     <= CW'(64);
            r_cfg_mode  <= PAD_NONE;
            r_ci        <= '0;
            r_ri        <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_transp    <= n_transp;
            r_cfg_w     <= n_cfg_w;
            r_cfg_h     <= n_cfg_h;
            r_cfg_mode  <= n_cfg_mode;
            r_ci        <= n_ci;
            r_ri        <= n_ri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_cols  <= n_cols;
        r_rows  <= n_rows;
        r_nc    <= n_nc;
        r_nr    <= n_nr;
        r_color <= n_color;
    end

    pts_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(r_color),
        .o_rdata(mem_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire
